[sv/page_table_mapper_with_free_pool_defines.svh]
// Assertion macros for the page table mapper.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef PAGE_TABLE_MAPPER_WITH_FREE_POOL_DEFINES_SVH
`define PAGE_TABLE_MAPPER_WITH_FREE_POOL_DEFINES_SVH
`ifndef SYNTHESIS
`define PTM_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define PTM_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define PTM_ASSERT_IMP(lbl, clk, rst, a, c, msg)
`define PTM_ASSERT_NXT(lbl, clk, rst, a, c, msg)
`endif
`endif

[sv/ptm_pkg.sv]
// Shared types and constants of the page table mapper.
// No dependencies.
`timescale 1ns / 1ps
package ptm_pkg;
  localparam int TABLE_FRAMES_DEF = 64;
  localparam int IDX_W = 9;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int VPN_W = 36;
  localparam int PHYS_W = 40;
  localparam int ENTRY_W = 52;
  localparam int LFRAME_W = 6;

  localparam logic [1:0] OP_FREE = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_MAP = 2'd2;
  localparam logic [1:0] OP_RO = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_REMAP = 2'd2;
  localparam logic [1:0] ST_NOTMAP = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       mod_entry;
    logic       push;
    logic       rd_issue;
    logic       pop;
    logic       pop_latch;
    logic       zero_wr;
    logic       link;
    logic       leaf_wr;
    logic       ro_wr;
    logic       level_dec;
    logic       set_frame;
    logic       set_status;
    logic [1:0] status;
    logic       out_load;
  } ptm_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       mod_busy;
    logic       present;
    logic       level_one;
    logic       pool_empty;
    logic       pool_full;
    logic       sweep_last;
    logic       out_free;
  } ptm_sts_t;
endpackage

[sv/ptm_datapath.sv]
// Datapath of the page table mapper: table store, free stack, modulo unit, result register.
// Depends on ptm_pkg.
`timescale 1ns / 1ps
module ptm_datapath import ptm_pkg::*; #(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [PHYS_W-1:0]   cfg_data,
  input  logic [1:0]          opcode,
  input  logic [LFRAME_W-1:0] frame_in,
  input  logic [LFRAME_W-1:0] root_frame,
  input  logic [VPN_W-1:0]    virt_page_number,
  input  logic [PHYS_W-1:0]   phys_frame,
  input  logic                writable,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [LFRAME_W-1:0] frame_out,
  output logic [ENTRY_W-1:0]  entry_out,
  input  ptm_cmd_t            cmd,
  output ptm_sts_t            sts
);
  localparam int FW = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int CW = $clog2(TABLE_FRAMES + 1);
  localparam int AW = FW + IDX_W;
  localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int MOD_STEPS = 4;
  localparam logic [FW-1:0] FOLD_C = FW'((1 << 20) % TABLE_FRAMES);
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / TABLE_FRAMES + 1);

  logic [ENTRY_W-1:0] store [DEPTH];
  logic [FW-1:0]      stack [TABLE_FRAMES];

  logic [PHYS_W-1:0]  base;
  logic [1:0]         op;
  logic [VPN_W-1:0]   vpn;
  logic [PHYS_W-1:0]  phys;
  logic               wr;
  logic [1:0]         level;
  logic [FW-1:0]      frame;
  logic [AW-1:0]      addr;
  logic [FW-1:0]      fresh;
  logic [IDX_W-1:0]   sweep;
  logic [CW-1:0]      count;
  logic [PHYS_W-1:0]  mod_dvd;
  logic [FW-1:0]      mod_rem;
  logic [2:0]         mod_cnt;
  logic [30:0]        fold1;
  logic [20:0]        fold2;
  logic [20:0]        quot;
  logic [ENTRY_W-1:0] rdata;
  logic [FW-1:0]      stack_rdata;
  logic [1:0]         st_work;
  logic [LFRAME_W-1:0] fo_work;
  logic [ENTRY_W-1:0] eo_work;

  logic [IDX_W-1:0]   idx;
  logic [CW-1:0]      count_m1;
  logic [ENTRY_W-1:0] leaf_entry;
  logic [ENTRY_W-1:0] ro_entry;
  logic [ENTRY_W-1:0] ptr_entry;
  logic [PHYS_W-1:0]  ptr_frame;
  logic [FW+LFRAME_W-1:0] fresh_ext;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;

  always_comb begin
    case (level)
      2'd3: idx = vpn[35:27];
      2'd2: idx = vpn[26:18];
      2'd1: idx = vpn[17:9];
      default: idx = vpn[8:0];
    endcase
  end

  assign count_m1 = count - CW'(1);
  assign leaf_entry = {phys, 10'b0, wr, 1'b1};
  assign ro_entry = rdata & ~ENTRY_W'(2);
  assign ptr_frame = base + PHYS_W'(fresh);
  assign ptr_entry = {ptr_frame, 10'b0, 2'b11};
  assign fresh_ext = {{LFRAME_W{1'b0}}, fresh};

  always_comb begin
    we = cmd.zero_wr | cmd.link | cmd.leaf_wr | cmd.ro_wr;
    waddr = addr;
    wdata = ptr_entry;
    if (cmd.zero_wr) begin
      waddr = {fresh, sweep};
      wdata = '0;
    end else if (cmd.leaf_wr) begin
      wdata = leaf_entry;
    end else if (cmd.ro_wr) begin
      wdata = ro_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (cmd.rd_issue) begin
      rdata <= store[{frame, idx}];
    end
    if (cmd.push) begin
      stack[count[FW-1:0]] <= mod_rem;
    end
    if (cmd.pop) begin
      stack_rdata <= stack[count_m1[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      count <= '0;
      mod_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        base <= cfg_data;
      end
      if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count_m1;
      end
      if (cmd.accept) begin
        mod_cnt <= 3'(MOD_STEPS);
      end else if (cmd.mod_entry) begin
        mod_cnt <= 3'(MOD_STEPS);
      end else if (mod_cnt != '0) begin
        mod_cnt <= mod_cnt - 3'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The frame number is folded twice by 2^20 mod TABLE_FRAMES, then reduced
  // by a reciprocal multiplication that is exact below 2^21.
  always_ff @(posedge clk) begin
    if (mod_cnt != '0) begin
      fold1 <= 31'(mod_dvd[PHYS_W-1:20]) * 31'(FOLD_C) + 31'(mod_dvd[19:0]);
      fold2 <= 21'(fold1[30:20]) * 21'(FOLD_C) + 21'(fold1[19:0]);
      quot <= 21'((53'(fold2) * 53'(RECIP)) >> 31);
      mod_rem <= FW'(fold2 - 21'(quot * 21'(TABLE_FRAMES)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= opcode;
      vpn <= virt_page_number;
      phys <= phys_frame;
      wr <= writable;
      level <= 2'd3;
      mod_dvd <= {{(PHYS_W-LFRAME_W){1'b0}}, (opcode == OP_FREE) ? frame_in : root_frame};
      st_work <= ST_OK;
      fo_work <= '0;
      eo_work <= '0;
    end else begin
      if (cmd.mod_entry) begin
        mod_dvd <= rdata[ENTRY_W-1:12] - base;
      end
      if (cmd.level_dec) begin
        level <= level - 2'd1;
      end
      if (cmd.set_status) begin
        st_work <= cmd.status;
      end
      if (cmd.leaf_wr) begin
        eo_work <= leaf_entry;
      end else if (cmd.ro_wr) begin
        eo_work <= ro_entry;
      end
      if (cmd.zero_wr && op == OP_ALLOC) begin
        fo_work <= fresh_ext[LFRAME_W-1:0];
      end
    end
    if (cmd.out_load) begin
      status <= st_work;
      frame_out <= fo_work;
      entry_out <= eo_work;
    end
    if (cmd.set_frame) begin
      frame <= mod_rem;
    end else if (cmd.link) begin
      frame <= fresh;
    end
    if (cmd.rd_issue) begin
      addr <= {frame, idx};
    end
    if (cmd.pop_latch) begin
      fresh <= stack_rdata;
      sweep <= '0;
    end else if (cmd.zero_wr) begin
      sweep <= sweep + IDX_W'(1);
    end
  end

  always_comb begin
    sts.op = op;
    sts.mod_busy = (mod_cnt != '0);
    sts.present = rdata[0];
    sts.level_one = (level == 2'd0);
    sts.pool_empty = (count == '0);
    sts.pool_full = (count == CW'(TABLE_FRAMES));
    sts.sweep_last = (sweep == {IDX_W{1'b1}});
    sts.out_free = !out_valid || !out_stall;
  end
endmodule

[sv/ptm_ctrl.sv]
// Controller state machine of the page table mapper.
// Depends on ptm_pkg; drives the datapath through ptm_cmd_t.
`timescale 1ns / 1ps
module ptm_ctrl import ptm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output ptm_cmd_t cmd,
  input  ptm_sts_t sts
);
  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_MOD      = 10'b0000000100,
    S_RDREQ    = 10'b0000001000,
    S_RDWAIT   = 10'b0000010000,
    S_POP      = 10'b0000100000,
    S_POPWAIT  = 10'b0001000000,
    S_ZERO     = 10'b0010000000,
    S_LINK     = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op != OP_ALLOC) begin
          state_next = S_MOD;
        end else if (sts.pool_empty) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_EMPTY;
          state_next = S_FIN;
        end else begin
          state_next = S_POP;
        end
      end
      S_MOD: begin
        if (!sts.mod_busy) begin
          if (sts.op == OP_FREE) begin
            cmd.push = !sts.pool_full;
            state_next = S_FIN;
          end else begin
            cmd.set_frame = 1'b1;
            state_next = S_RDREQ;
          end
        end
      end
      S_RDREQ: begin
        cmd.rd_issue = 1'b1;
        state_next = S_RDWAIT;
      end
      S_RDWAIT: begin
        if (!sts.level_one) begin
          if (sts.present) begin
            cmd.mod_entry = 1'b1;
            cmd.level_dec = 1'b1;
            state_next = S_MOD;
          end else if (sts.op == OP_RO) begin
            cmd.set_status = 1'b1;
            cmd.status = ST_NOTMAP;
            state_next = S_FIN;
          end else if (sts.pool_empty) begin
            cmd.set_status = 1'b1;
            cmd.status = ST_EMPTY;
            state_next = S_FIN;
          end else begin
            state_next = S_POP;
          end
        end else begin
          if (sts.op == OP_MAP) begin
            if (sts.present) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_REMAP;
            end else begin
              cmd.leaf_wr = 1'b1;
            end
          end else if (sts.present) begin
            cmd.ro_wr = 1'b1;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status = ST_NOTMAP;
          end
          state_next = S_FIN;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_next = S_POPWAIT;
      end
      S_POPWAIT: begin
        cmd.pop_latch = 1'b1;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.zero_wr = 1'b1;
        if (sts.sweep_last) begin
          state_next = (sts.op == OP_ALLOC) ? S_FIN : S_LINK;
        end
      end
      S_LINK: begin
        cmd.link = 1'b1;
        cmd.level_dec = 1'b1;
        state_next = S_RDREQ;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

[sv/page_table_mapper_with_free_pool.sv]
// Top level of the page table mapper with its free frame pool.
// Depends on ptm_pkg, ptm_ctrl, ptm_datapath and the assertion macro header.
`timescale 1ns / 1ps
// One transaction is handled at a time. The time of free is set by a frame number reduction,
// that of allocate by the zeroing sweep of all 512 entries of a table frame. Map and read-only
// walk up to four levels, each level walked being a frame reduction plus one registered table
// read; each table that map allocates adds the zeroing sweep of a table frame. A finished result
// is held in an output register, so the next transaction may be accepted while the result still waits.
`include "page_table_mapper_with_free_pool_defines.svh"
module page_table_mapper_with_free_pool import ptm_pkg::*; #(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PHYS_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [LFRAME_W-1:0] frame_in,
  input  logic [LFRAME_W-1:0] root_frame,
  input  logic [VPN_W-1:0]    virt_page_number,
  input  logic [PHYS_W-1:0]   phys_frame,
  input  logic                writable,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [LFRAME_W-1:0] frame_out,
  output logic [ENTRY_W-1:0]  entry_out
);
  ptm_cmd_t cmd;
  ptm_sts_t sts;

  assign cfg_ready = 1'b1;

  ptm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ptm_datapath #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .opcode           (opcode),
    .frame_in         (frame_in),
    .root_frame       (root_frame),
    .virt_page_number (virt_page_number),
    .phys_frame       (phys_frame),
    .writable         (writable),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .status           (status),
    .frame_out        (frame_out),
    .entry_out        (entry_out),
    .cmd              (cmd),
    .sts              (sts)
  );

  `PTM_ASSERT_NXT(a_stall_after_accept, clk, rst, in_valid && !in_stall, in_stall, "no stall after accept")
  `PTM_ASSERT_IMP(a_push_not_full, clk, rst, cmd.push, !sts.pool_full, "push on full pool")
  `PTM_ASSERT_IMP(a_pop_not_empty, clk, rst, cmd.pop, !sts.pool_empty, "pop on empty pool")
  `PTM_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && status != ST_OK, entry_out == '0 && frame_out == '0, "failed result carries data")
endmodule
